// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the blend pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rab_pkg.sv -----
// ----------------------------------------------------------------------------
// rab_pkg
// Types and constants of the RGB555 alpha blend pipeline.
// ----------------------------------------------------------------------------
package rab_pkg;

	localparam int unsigned PIX_W   = 16;
	localparam int unsigned ALPHA_W = 8;
	localparam int unsigned CH_W    = 5;
	localparam int unsigned CFG_IDX_W = 2;

	// channel positions inside a pixel
	localparam int unsigned RED_LSB   = 0;
	localparam int unsigned GREEN_LSB = 5;
	localparam int unsigned BLUE_LSB  = 10;
	localparam int unsigned VALID_POS = 15;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BELOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_CEILING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPAQUE_FROM   = 2'd2;

	// register reset values
	localparam logic [ALPHA_W-1:0] SKIP_BELOW_RST    = 8'd8;
	localparam logic [ALPHA_W-1:0] BLEND_CEILING_RST = 8'd247;
	localparam logic [ALPHA_W-1:0] OPAQUE_FROM_RST   = 8'd128;

	// rounding offsets for red and green (green is folded from *32 / 8192)
	localparam logic signed [14:0] RED_ROUND   = 15'sd128;
	localparam logic signed [14:0] GREEN_ROUND = 15'sd4;

	// what to do with a pixel
	typedef enum logic [1:0] {
		ACT_KEEP  = 2'b00,
		ACT_BLEND = 2'b01,
		ACT_COPY  = 2'b10
	} act_t;

endpackage

// ----- src/rgb555_alpha_blend.sv -----
// ----------------------------------------------------------------------------
// rgb555_alpha_blend
// Three-stage pipeline compositing a 5-5-5 source pixel onto a destination.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive source_pixel, source_alpha and dest_pixel with start high;
//   the transaction is taken at a rising edge where start is high and busy is
//   low. busy stays low: the pipeline takes one pixel every cycle.
//   Output: done pulses for one cycle with write_enable and result_pixel. The
//   receiver cannot hold results off, and none is needed: results leave in
//   the order pixels came in, passing through each stage register in turn.
//   Throughput is one pixel per cycle; the three stages are decode/compare,
//   the signed 6x9 channel multiplies, and shift/add/select.
//   Configuration: cfg_valid with cfg_index and cfg_data writes one threshold
//   register (0 skip_below, 1 blend_ceiling, 2 opaque_from); cfg_ready is
//   always high. Write only while no pixel is in flight.
//   Reset (arst_n low): the pipeline empties, done drops, and the thresholds
//   return to 8, 247 and 128.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb555_alpha_blend (
	input  logic                               clk,
	input  logic                               arst_n,
	// pixel input
	input  logic                               start,
	output logic                               busy,
	input  logic [rab_pkg::PIX_W-1:0]          source_pixel,
	input  logic [rab_pkg::ALPHA_W-1:0]        source_alpha,
	input  logic [rab_pkg::PIX_W-1:0]          dest_pixel,
	// result output
	output logic                               done,
	output logic                               write_enable,
	output logic [rab_pkg::PIX_W-1:0]          result_pixel,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rab_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rab_pkg::ALPHA_W-1:0]        cfg_data
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [rab_pkg::ALPHA_W-1:0] skip_below_q;
	logic [rab_pkg::ALPHA_W-1:0] blend_ceiling_q;
	logic [rab_pkg::ALPHA_W-1:0] opaque_from_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// Drop writes to indexes beyond the register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_below_q    <= rab_pkg::SKIP_BELOW_RST;
			blend_ceiling_q <= rab_pkg::BLEND_CEILING_RST;
			opaque_from_q   <= rab_pkg::OPAQUE_FROM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rab_pkg::CFG_SKIP_BELOW:    skip_below_q    <= cfg_data;
				rab_pkg::CFG_BLEND_CEILING: blend_ceiling_q <= cfg_data;
				rab_pkg::CFG_OPAQUE_FROM:   opaque_from_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: decide the action and form signed channel differences
	// ------------------------------------------------------------------
	logic                 take;
	rab_pkg::act_t        act_d;
	logic signed [5:0]    dr_d, dg_d, db_d;

	assign take = start && !busy;

	// Skip test first, then blend against a valid destination, then copy.
	always_comb begin
		act_d = rab_pkg::ACT_KEEP;
		if (source_alpha >= skip_below_q) begin
			if (dest_pixel[rab_pkg::VALID_POS] && (source_alpha <= blend_ceiling_q)) begin
				act_d = rab_pkg::ACT_BLEND;
			end else if (source_alpha >= opaque_from_q) begin
				act_d = rab_pkg::ACT_COPY;
			end
		end
	end

	// Channel difference source minus destination, range -31..31.
	assign dr_d = $signed({1'b0, source_pixel[rab_pkg::RED_LSB   +: rab_pkg::CH_W]})
	            - $signed({1'b0, dest_pixel[rab_pkg::RED_LSB     +: rab_pkg::CH_W]});
	assign dg_d = $signed({1'b0, source_pixel[rab_pkg::GREEN_LSB +: rab_pkg::CH_W]})
	            - $signed({1'b0, dest_pixel[rab_pkg::GREEN_LSB   +: rab_pkg::CH_W]});
	assign db_d = $signed({1'b0, source_pixel[rab_pkg::BLUE_LSB  +: rab_pkg::CH_W]})
	            - $signed({1'b0, dest_pixel[rab_pkg::BLUE_LSB    +: rab_pkg::CH_W]});

	logic                          valid_s1;
	rab_pkg::act_t                 act_s1;
	logic signed [5:0]             dr_s1, dg_s1, db_s1;
	logic [rab_pkg::ALPHA_W-1:0]   alpha_s1;
	logic [rab_pkg::PIX_W-1:0]     src_s1, dest_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_s1   <= act_d;
			dr_s1    <= dr_d;
			dg_s1    <= dg_d;
			db_s1    <= db_d;
			alpha_s1 <= source_alpha;
			src_s1   <= source_pixel;
			dest_s1  <= dest_pixel;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: scale each difference by alpha, add rounding
	// ------------------------------------------------------------------
	logic signed [8:0]  alpha_sx;
	logic signed [14:0] mr, mg, mb;

	assign alpha_sx = $signed({1'b0, alpha_s1});
	assign mr = 15'(dr_s1) * 15'(alpha_sx);
	assign mg = 15'(dg_s1) * 15'(alpha_sx);
	assign mb = 15'(db_s1) * 15'(alpha_sx);

	logic                       valid_s2;
	rab_pkg::act_t              act_s2;
	logic signed [14:0]         pr_s2, pg_s2, pb_s2;
	logic [rab_pkg::PIX_W-1:0]  src_s2, dest_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Blue is truncated, red and green round.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			act_s2  <= act_s1;
			pr_s2   <= mr + rab_pkg::RED_ROUND;
			pg_s2   <= mg + rab_pkg::GREEN_ROUND;
			pb_s2   <= mb;
			src_s2  <= src_s1;
			dest_s2 <= dest_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: floor-divide by 256, add to destination, pick the result
	// ------------------------------------------------------------------
	// Only the low five bits of the arithmetic shift matter for a 5-bit sum.
	logic [rab_pkg::CH_W-1:0]  r_new, g_new, b_new;
	logic [rab_pkg::PIX_W-1:0] blend_pix;
	logic [rab_pkg::PIX_W-1:0] res_d;
	logic                      we_d;

	assign r_new = dest_s2[rab_pkg::RED_LSB   +: rab_pkg::CH_W] + pr_s2[12:8];
	assign g_new = dest_s2[rab_pkg::GREEN_LSB +: rab_pkg::CH_W] + pg_s2[12:8];
	assign b_new = dest_s2[rab_pkg::BLUE_LSB  +: rab_pkg::CH_W] + pb_s2[12:8];
	assign blend_pix = {1'b1, b_new, g_new, r_new};

	always_comb begin
		case (act_s2)
			rab_pkg::ACT_BLEND: begin
				res_d = blend_pix;
				we_d  = 1'b1;
			end
			rab_pkg::ACT_COPY: begin
				res_d = {1'b1, src_s2[rab_pkg::VALID_POS-1:0]};
				we_d  = 1'b1;
			end
			default: begin
				res_d = dest_s2;
				we_d  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			result_pixel <= res_d;
			write_enable <= we_d;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	logic kept_out;
	logic wrote_out;
	logic res_valid;
	logic below_skip;

	assign kept_out   = done && !write_enable;
	assign wrote_out  = done && write_enable;
	assign res_valid  = result_pixel[rab_pkg::VALID_POS];
	assign below_skip = source_alpha < skip_below_q;

	`ASSERT_NEXT(a_latency, clk, arst_n, take, ##2 done, "pixel not delivered in three cycles")
	`ASSERT_SAME(a_keep, clk, arst_n, kept_out, result_pixel == $past(dest_pixel, 3), "kept pixel")
	`ASSERT_SAME(a_valid, clk, arst_n, wrote_out, res_valid, "written pixel lacks valid bit")
	`ASSERT_NEXT(a_skip, clk, arst_n, take && below_skip, ##2 !write_enable, "skip ignored")

endmodule

// ----- bench/tb_rgb555_alpha_blend.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb555_alpha_blend
// Self-checking bench for the RGB555 alpha compositing pipeline.
// ----------------------------------------------------------------------------
// Pixels go in through the start/busy handshake. Each accepted transaction is
// composited by an in-bench predictor against the current threshold settings,
// and the prediction is queued. Every done strobe pops the oldest prediction
// and compares write_enable and result_pixel. A directed part covers the
// threshold edges, the alpha extremes, out-of-order thresholds and the valid
// bit handling. A random part then runs several threshold settings with
// bursty input traffic.
// ----------------------------------------------------------------------------
module tb_rgb555_alpha_blend;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_REPORTS   = 10;
	localparam int ITEMS_PER_SET = 205;

	// index with no register behind it; writes there must change nothing
	localparam logic [rab_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// one predicted composite, with the transaction that caused it
	typedef struct packed {
		logic [rab_pkg::PIX_W-1:0]   src;
		logic [rab_pkg::ALPHA_W-1:0] alpha;
		logic [rab_pkg::PIX_W-1:0]   dst;
		logic                        wr;
		logic [rab_pkg::PIX_W-1:0]   pix;
	} composite_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          start        = 1'b0;
	logic [rab_pkg::PIX_W-1:0]     source_pixel = '0;
	logic [rab_pkg::ALPHA_W-1:0]   source_alpha = '0;
	logic [rab_pkg::PIX_W-1:0]     dest_pixel   = '0;
	logic                          cfg_valid    = 1'b0;
	logic [rab_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [rab_pkg::ALPHA_W-1:0]   cfg_data     = '0;
	logic                          busy;
	logic                          done;
	logic                          write_enable;
	logic [rab_pkg::PIX_W-1:0]     result_pixel;
	logic                          cfg_ready;

	// bench copy of the threshold registers
	logic [rab_pkg::ALPHA_W-1:0] skip_below    = rab_pkg::SKIP_BELOW_RST;
	logic [rab_pkg::ALPHA_W-1:0] blend_ceiling = rab_pkg::BLEND_CEILING_RST;
	logic [rab_pkg::ALPHA_W-1:0] opaque_from   = rab_pkg::OPAQUE_FROM_RST;

	composite_t pending_pixels[$];
	composite_t oldest;
	int         failures    = 0;
	int         cycle_count = 0;
	int         burst_left  = 0;

	rgb555_alpha_blend uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.source_pixel (source_pixel),
		.source_alpha (source_alpha),
		.dest_pixel   (dest_pixel),
		.done         (done),
		.write_enable (write_enable),
		.result_pixel (result_pixel),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Composite one pixel under the current thresholds. The skip test wins
	// over everything, then blending with a valid destination, then the
	// opaque copy. Floor division by a power of two is an arithmetic shift.
	function automatic composite_t predict_composite(
			input logic [rab_pkg::PIX_W-1:0] src,
			input logic [rab_pkg::ALPHA_W-1:0] alpha,
			input logic [rab_pkg::PIX_W-1:0] dst);
		composite_t    res;
		rab_pkg::act_t action;
		int            a, rs, rd, gs, gd, bs, bd, red, green, blue;
		action = rab_pkg::ACT_KEEP;
		if (alpha >= skip_below) begin
			if (dst[rab_pkg::VALID_POS] && alpha <= blend_ceiling)
				action = rab_pkg::ACT_BLEND;
			else if (alpha >= opaque_from)
				action = rab_pkg::ACT_COPY;
		end
		res.src   = src;
		res.alpha = alpha;
		res.dst   = dst;
		res.wr    = (action != rab_pkg::ACT_KEEP);
		res.pix   = dst;
		case (action)
			rab_pkg::ACT_BLEND: begin
				a  = int'(alpha);
				rs = int'(src[rab_pkg::RED_LSB +: rab_pkg::CH_W]);
				rd = int'(dst[rab_pkg::RED_LSB +: rab_pkg::CH_W]);
				gs = int'(src[rab_pkg::GREEN_LSB +: rab_pkg::CH_W]);
				gd = int'(dst[rab_pkg::GREEN_LSB +: rab_pkg::CH_W]);
				bs = int'(src[rab_pkg::BLUE_LSB +: rab_pkg::CH_W]);
				bd = int'(dst[rab_pkg::BLUE_LSB +: rab_pkg::CH_W]);
				// red and green round, blue truncates toward minus infinity
				red   = rd + (((rs - rd) * a + 128) >>> 8);
				green = gd + (((gs - gd) * a * 32 + 128) >>> 13);
				blue  = bd + (((bs - bd) * a) >>> 8);
				res.pix = {1'b1, blue[rab_pkg::CH_W-1:0], green[rab_pkg::CH_W-1:0],
					red[rab_pkg::CH_W-1:0]};
			end
			rab_pkg::ACT_COPY: begin
				// source valid bit is forced on
				res.pix = {1'b1, src[rab_pkg::PIX_W-2:0]};
			end
			default: ;
		endcase
		return res;
	endfunction

	// Drive one pixel and hold it until the block takes it. Leave start high
	// on return so that a following transaction can go out back to back.
	task automatic send_pixel(input logic [rab_pkg::PIX_W-1:0] src,
			input logic [rab_pkg::ALPHA_W-1:0] alpha,
			input logic [rab_pkg::PIX_W-1:0] dst);
		start        <= 1'b1;
		source_pixel <= src;
		source_alpha <= alpha;
		dest_pixel   <= dst;
		do @(posedge clk); while (busy);
		pending_pixels.push_back(predict_composite(src, alpha, dst));
	endtask

	// Drop start and wait until every queued composite has come back.
	task automatic drain;
		start <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
	endtask

	// Write one register and hold valid until it is taken; update the bench
	// copy at the same edge.
	task automatic write_register(input logic [rab_pkg::CFG_IDX_W-1:0] idx,
			input logic [rab_pkg::ALPHA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rab_pkg::CFG_SKIP_BELOW:    skip_below    = value;
			rab_pkg::CFG_BLEND_CEILING: blend_ceiling = value;
			rab_pkg::CFG_OPAQUE_FROM:   opaque_from   = value;
			default: ;
		endcase
	endtask

	// Empty the pipeline, then load all three thresholds plus a write to the
	// unused index that must leave them alone.
	task automatic set_thresholds(input logic [rab_pkg::ALPHA_W-1:0] skip,
			input logic [rab_pkg::ALPHA_W-1:0] ceil,
			input logic [rab_pkg::ALPHA_W-1:0] opaque);
		drain();
		write_register(CFG_UNUSED, rab_pkg::ALPHA_W'($urandom));
		write_register(rab_pkg::CFG_BLEND_CEILING, ceil);
		write_register(rab_pkg::CFG_OPAQUE_FROM, opaque);
		write_register(rab_pkg::CFG_SKIP_BELOW, skip);
		cfg_valid <= 1'b0;
	endtask

	// Bursty sender: advance through the current burst, and at its end hold
	// start low for a short random gap. Some bursts are long, with no gaps.
	task automatic pace_sender;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(40, 120);
			else
				burst_left = $urandom_range(0, 12);
		end
	endtask

	// Pick alpha mostly right on or next to a threshold, else 0, 255 or uniform.
	function automatic logic [rab_pkg::ALPHA_W-1:0] pick_alpha;
		case ($urandom_range(0, 9))
			0: return skip_below - 8'd1;
			1: return skip_below;
			2: return blend_ceiling;
			3: return blend_ceiling + 8'd1;
			4: return opaque_from - 8'd1;
			5: return opaque_from;
			6: return ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd255;
			default: return rab_pkg::ALPHA_W'($urandom);
		endcase
	endfunction

	// Edges of the reset thresholds: skip, blend at both ends, copy with and
	// without a valid destination, and source valid bit handling.
	task automatic test_reset_thresholds;
		send_pixel(16'hFFFF, 8'd0,   16'h8000);
		send_pixel(16'h7FFF, 8'd7,   16'hFFFF);
		send_pixel(16'h7FFF, 8'd8,   16'h8000);
		send_pixel(16'h0000, 8'd8,   16'hFFFF);
		send_pixel(16'h7FFF, 8'd247, 16'h8000);
		send_pixel(16'h0000, 8'd247, 16'hFFFF);
		send_pixel(16'h7FFF, 8'd248, 16'h8000);
		send_pixel(16'h1234, 8'd255, 16'hFFFF);
		send_pixel(16'hFFFF, 8'd127, 16'h7FFF);
		send_pixel(16'h0421, 8'd128, 16'h0000);
		send_pixel(16'hFFFF, 8'd200, 16'h83E0);
		send_pixel(16'h5555, 8'd128, 16'hAAAA);
		drain();
	endtask

	// Thresholds out of order: skip above ceiling above opaque.
	task automatic test_threshold_order;
		set_thresholds(8'd200, 8'd100, 8'd50);
		send_pixel(16'h7FFF, 8'd150, 16'hFFFF);
		send_pixel(16'h7FFF, 8'd199, 16'h0000);
		send_pixel(16'h001F, 8'd200, 16'h8000);
		send_pixel(16'h7C00, 8'd255, 16'h7FFF);
		drain();
	endtask

	// Blend at the alpha extremes, zero and 255, plus invalid destinations that keep or copy.
	task automatic test_blend_extremes;
		set_thresholds(8'd0, 8'd255, 8'd255);
		send_pixel(16'h7FFF, 8'd255, 16'h8000);
		send_pixel(16'h0000, 8'd255, 16'hFFFF);
		send_pixel(16'h7FFF, 8'd0,   16'hFFFF);
		send_pixel(16'h7FFF, 8'd254, 16'h7FFF);
		send_pixel(16'h0000, 8'd255, 16'h0000);
		drain();
	endtask

	// Random pixels under a series of settings, extremes first, then two
	// random ones and finally back to the reset values.
	task automatic test_random_stream;
		logic [rab_pkg::ALPHA_W-1:0] skips[8] =
			'{8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd0, 8'd8};
		logic [rab_pkg::ALPHA_W-1:0] ceils[8] =
			'{8'd255, 8'd255, 8'd0, 8'd64, 8'd0, 8'd0, 8'd0, 8'd247};
		logic [rab_pkg::ALPHA_W-1:0] opaques[8] =
			'{8'd0, 8'd255, 8'd255, 8'd200, 8'd0, 8'd0, 8'd0, 8'd128};
		for (int s = 0; s < 8; s++) begin
			if (s == 5 || s == 6) begin
				skips[s]   = rab_pkg::ALPHA_W'($urandom);
				ceils[s]   = rab_pkg::ALPHA_W'($urandom);
				opaques[s] = rab_pkg::ALPHA_W'($urandom);
			end
			set_thresholds(skips[s], ceils[s], opaques[s]);
			burst_left = 0;
			for (int i = 0; i < ITEMS_PER_SET; i++) begin
				send_pixel(rab_pkg::PIX_W'($urandom), pick_alpha(),
					rab_pkg::PIX_W'($urandom));
				// now and then, hold off until the pipeline has emptied
				if ($urandom_range(0, 99) == 0)
					drain();
				else
					pace_sender();
			end
		end
		drain();
	endtask

	// Compare each done strobe with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("unexpected result: write_enable %0b result_pixel %h",
						write_enable, result_pixel);
			end else begin
				oldest = pending_pixels.pop_front();
				if (write_enable !== oldest.wr || result_pixel !== oldest.pix) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("mismatch %h/%0d/%h: we exp %0b got %0b, pix exp %h got %h",
							oldest.src, oldest.alpha, oldest.dst, oldest.wr, write_enable,
							oldest.pix, result_pixel);
				end
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL rgb555_alpha_blend");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_thresholds();
		test_threshold_order();
		test_blend_extremes();
		test_random_stream();
		// let any stray strobe show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		failures += pending_pixels.size();
		if (failures == 0)
			$display("PASS rgb555_alpha_blend");
		else
			$display("FAIL rgb555_alpha_blend");
		$finish;
	end

endmodule
